// ----- rtl/fhs_pkg.sv -----
// Package for the FNV-1a hash set: key geometry, hash constants, status and
// operation codes, the command type handed from front to back, key helpers.
// No dependencies.
package fhs_pkg;

  // Key geometry
  localparam int KEY_CHARS = 6;
  localparam int TEXT_W    = 8 * KEY_CHARS;
  localparam int LEN_W     = 3;
  localparam int ENTRY_W   = LEN_W + TEXT_W;

  // Fixed field widths on the stream ports
  localparam int POS_W = 10;
  localparam int CNT_W = 10;
  localparam int STS_W = 2;

  // Defaults for the top-level parameters
  localparam int TABLE_SLOTS_DEF = 1024;
  localparam int CMD_FIFO_DEPTH  = 2;

  // Register reset value
  localparam logic [CNT_W-1:0] MAX_ENTRIES_RST = 10'd716;

  // FNV-1a 32-bit constants
  localparam logic [31:0] FNV_BASIS = 32'h811C_9DC5;
  localparam logic [31:0] FNV_PRIME = 32'h0100_0193;

  // Operation codes
  localparam logic FUNC_INSERT = 1'b0;
  localparam logic FUNC_READ   = 1'b1;

  // Result status codes
  localparam logic [STS_W-1:0] ST_ADDED   = 2'd0;
  localparam logic [STS_W-1:0] ST_PRESENT = 2'd1;
  localparam logic [STS_W-1:0] ST_FULL    = 2'd2;
  localparam logic [STS_W-1:0] ST_READ    = 2'd3;

  // Command handed from front to back (slot index travels beside it)
  typedef struct packed {
    logic              func;
    logic [LEN_W-1:0]  len;
    logic [TEXT_W-1:0] text;
  } key_cmd_t;

  // Clamp a key length into 1..KEY_CHARS
  function automatic logic [LEN_W-1:0] norm_len(input logic [LEN_W-1:0] len);
    logic [LEN_W-1:0] res;
    res = len;
    if (len == '0) begin
      res = LEN_W'(1);
    end else if (len > LEN_W'(KEY_CHARS)) begin
      res = LEN_W'(KEY_CHARS);
    end
    return res;
  endfunction

  // Zero every byte at or beyond the key length (first byte in the top bits)
  function automatic logic [TEXT_W-1:0] mask_key(input logic [TEXT_W-1:0] text,
                                                 input logic [LEN_W-1:0]  len);
    logic [TEXT_W-1:0] res;
    res = '0;
    for (int i = 0; i < KEY_CHARS; i++) begin
      if (LEN_W'(i) < len) begin
        res[TEXT_W-1-8*i -: 8] = text[TEXT_W-1-8*i -: 8];
      end
    end
    return res;
  endfunction

endpackage

// ----- rtl/fhs_ram.sv -----
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fhs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // Write and registered read
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/fhs_cmd_fifo.sv -----
// Short command queue between the hashing front and the probing back.
// No dependencies.
module fhs_cmd_fifo #(
  parameter int DATA_W = 8,
  parameter int DEPTH  = 2
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              push_i,
  input  logic [DATA_W-1:0] push_data_i,
  output logic              full_o,
  input  logic              pop_i,
  output logic              valid_o,
  output logic [DATA_W-1:0] pop_data_o
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [DATA_W-1:0] buf_q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  fill_q;
  logic              do_push, do_pop;

  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && valid_o;

  assign full_o     = (fill_q == CNT_W'(DEPTH));
  assign valid_o    = (fill_q != '0);
  assign pop_data_o = buf_q[rd_ptr_q];

  // Store pushed commands
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      buf_q[wr_ptr_q] <= push_data_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill_q <= fill_q + CNT_W'(1);
      end else if (do_pop && !do_push) begin
        fill_q <= fill_q - CNT_W'(1);
      end
    end
  end

endmodule

// ----- rtl/fhs_front.sv -----
// Front end: accepts input beats, normalizes the key, runs FNV-1a one byte
// per cycle and pushes a command with its home or read slot. Uses fhs_pkg.
module fhs_front #(
  parameter int TABLE_SLOTS = fhs_pkg::TABLE_SLOTS_DEF,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   clearing_i,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic                   func_i,
  input  logic [fhs_pkg::TEXT_W-1:0] key_text_i,
  input  logic [fhs_pkg::LEN_W-1:0]  key_length_i,
  input  logic [fhs_pkg::POS_W-1:0]  read_index_i,
  output logic                   push_o,
  output fhs_pkg::key_cmd_t      push_cmd_o,
  output logic [SLOT_W-1:0]      push_slot_o,
  input  logic                   fifo_full_i
);

  localparam logic [1:0] F_IDLE = 2'd0;
  localparam logic [1:0] F_HASH = 2'd1;
  localparam logic [1:0] F_PUSH = 2'd2;

  logic [1:0]                   st_q, st_d;
  fhs_pkg::key_cmd_t            cmd_q;
  logic [SLOT_W-1:0]            rd_slot_q;
  logic [31:0]                  h_q, h_d;
  logic [fhs_pkg::TEXT_W-1:0]   sh_q;
  logic [fhs_pkg::LEN_W-1:0]    cnt_q;
  logic [fhs_pkg::LEN_W-1:0]    len_n;
  logic [31:0]                  idx_ext;
  logic                         accept;

  assign in_ready_o = (st_q == F_IDLE) && !clearing_i;
  assign accept     = in_valid_i && in_ready_o;
  assign len_n      = fhs_pkg::norm_len(key_length_i);
  assign idx_ext    = 32'(read_index_i);

  // One FNV-1a round on the next key byte
  assign h_d = 32'((h_q ^ {24'b0, sh_q[fhs_pkg::TEXT_W-1 -: 8]}) * fhs_pkg::FNV_PRIME);

  // Push the finished command
  assign push_o      = (st_q == F_PUSH);
  assign push_cmd_o  = cmd_q;
  assign push_slot_o = (cmd_q.func == fhs_pkg::FUNC_READ) ? rd_slot_q : h_q[SLOT_W-1:0];

  // Sequence: accept, hash bytes (inserts only), push
  always_comb begin
    st_d = st_q;
    case (st_q)
      F_IDLE: begin
        if (accept) begin
          st_d = (func_i == fhs_pkg::FUNC_READ) ? F_PUSH : F_HASH;
        end
      end
      F_HASH: begin
        if (cnt_q == fhs_pkg::LEN_W'(1)) begin
          st_d = F_PUSH;
        end
      end
      F_PUSH: begin
        if (!fifo_full_i) begin
          st_d = F_IDLE;
        end
      end
      default: st_d = F_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= F_IDLE;
    end else begin
      st_q <= st_d;
    end
  end

  // Capture the key and step the hash
  always_ff @(posedge clk_i) begin
    if (accept) begin
      cmd_q.func <= func_i;
      cmd_q.len  <= len_n;
      cmd_q.text <= fhs_pkg::mask_key(key_text_i, len_n);
      rd_slot_q  <= idx_ext[SLOT_W-1:0];
      h_q        <= fhs_pkg::FNV_BASIS;
      sh_q       <= key_text_i;
      cnt_q      <= len_n;
    end else if (st_q == F_HASH) begin
      h_q   <= h_d;
      sh_q  <= {sh_q[fhs_pkg::TEXT_W-9:0], 8'h00};
      cnt_q <= cnt_q - fhs_pkg::LEN_W'(1);
    end
  end

endmodule

// ----- rtl/fhs_back.sv -----
// Back end: clears the slot store after reset, then pops commands and walks
// the linear probe sequence over the slot RAM, one slot per cycle.
// Uses fhs_pkg and fhs_ram.
module fhs_back #(
  parameter int TABLE_SLOTS = fhs_pkg::TABLE_SLOTS_DEF,
  localparam int SLOT_W     = $clog2(TABLE_SLOTS)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        cfg_we_i,
  input  logic [fhs_pkg::CNT_W-1:0]   cfg_wdata_i,
  output logic                        clearing_o,
  input  logic                        cmd_valid_i,
  input  fhs_pkg::key_cmd_t           cmd_i,
  input  logic [SLOT_W-1:0]           cmd_slot_i,
  output logic                        cmd_pop_o,
  output logic                        out_valid_o,
  input  logic                        out_ready_i,
  output logic [fhs_pkg::STS_W-1:0]   out_status_o,
  output logic [fhs_pkg::POS_W-1:0]   out_pos_o,
  output logic                        out_occ_o,
  output logic [fhs_pkg::TEXT_W-1:0]  out_text_o,
  output logic [fhs_pkg::LEN_W-1:0]   out_len_o,
  output logic [fhs_pkg::CNT_W-1:0]   out_count_o
);

  localparam logic [1:0] B_CLEAR = 2'd0;
  localparam logic [1:0] B_IDLE  = 2'd1;
  localparam logic [1:0] B_CHK   = 2'd2;

  logic [1:0]                      st_q, st_d;
  logic [SLOT_W-1:0]               clr_q;
  fhs_pkg::key_cmd_t               cmd_q;
  logic [SLOT_W-1:0]               pos_q, home_q, n_q;
  logic                            full_q;
  logic [fhs_pkg::CNT_W-1:0]       count_q, max_q;

  // RAM ports
  logic                            ram_we, ram_re;
  logic [SLOT_W-1:0]               ram_waddr, ram_raddr;
  logic [fhs_pkg::ENTRY_W-1:0]     ram_wdata, ram_rdata;

  logic [fhs_pkg::LEN_W-1:0]       ent_len;
  logic [fhs_pkg::TEXT_W-1:0]      ent_text;
  logic                            ent_occ, ent_hit, finish, do_add;
  logic [fhs_pkg::STS_W-1:0]       res_status;
  logic [SLOT_W-1:0]               res_pos, pos_nx;
  logic [fhs_pkg::CNT_W-1:0]       count_nx;
  logic [31:0]                     res_pos_ext;

  logic                            out_valid_q;
  logic [fhs_pkg::STS_W-1:0]       out_status_q;
  logic [fhs_pkg::POS_W-1:0]       out_pos_q;
  logic                            out_occ_q;
  logic [fhs_pkg::TEXT_W-1:0]      out_text_q;
  logic [fhs_pkg::LEN_W-1:0]       out_len_q;
  logic [fhs_pkg::CNT_W-1:0]       out_count_q;

  fhs_ram #(
    .WIDTH (fhs_pkg::ENTRY_W),
    .DEPTH (TABLE_SLOTS)
  ) u_slot_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign clearing_o = (st_q == B_CLEAR);

  // Decode the slot just read; an empty slot has length zero
  assign ent_len  = ram_rdata[fhs_pkg::ENTRY_W-1 -: fhs_pkg::LEN_W];
  assign ent_text = ram_rdata[fhs_pkg::TEXT_W-1:0];
  assign ent_occ  = (ent_len != '0);
  assign ent_hit  = ent_occ && (ent_len == cmd_q.len) && (ent_text == cmd_q.text);
  assign pos_nx   = pos_q + SLOT_W'(1);

  // Pop only when the output register is free, so a result never waits inside
  assign cmd_pop_o = (st_q == B_IDLE) && cmd_valid_i && (!out_valid_q || out_ready_i);

  // Probe decision
  always_comb begin
    finish     = 1'b0;
    do_add     = 1'b0;
    res_status = fhs_pkg::ST_READ;
    res_pos    = pos_q;
    if (st_q == B_CHK) begin
      if (full_q) begin
        finish     = 1'b1;
        res_status = fhs_pkg::ST_FULL;
        res_pos    = home_q;
      end else if (cmd_q.func == fhs_pkg::FUNC_READ) begin
        finish     = 1'b1;
        res_status = fhs_pkg::ST_READ;
      end else if (!ent_occ) begin
        finish = 1'b1;
        if (count_q >= max_q) begin
          res_status = fhs_pkg::ST_FULL;
        end else begin
          do_add     = 1'b1;
          res_status = fhs_pkg::ST_ADDED;
        end
      end else if (ent_hit) begin
        finish     = 1'b1;
        res_status = fhs_pkg::ST_PRESENT;
      end
    end
  end

  assign count_nx    = do_add ? count_q + fhs_pkg::CNT_W'(1) : count_q;
  assign res_pos_ext = 32'(res_pos);

  // RAM access: clear sweep, first probe, next probe or home re-read, insert
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pos_q;
    ram_wdata = {cmd_q.len, cmd_q.text};
    ram_re    = 1'b0;
    ram_raddr = pos_nx;
    case (st_q)
      B_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
      end
      B_IDLE: begin
        ram_re    = cmd_pop_o;
        ram_raddr = cmd_slot_i;
      end
      B_CHK: begin
        ram_we = do_add;
        if (!finish) begin
          ram_re    = 1'b1;
          ram_raddr = (n_q == SLOT_W'(TABLE_SLOTS - 1)) ? home_q : pos_nx;
        end
      end
      default: ;
    endcase
  end

  // Next state
  always_comb begin
    st_d = st_q;
    case (st_q)
      B_CLEAR: begin
        if (clr_q == SLOT_W'(TABLE_SLOTS - 1)) begin
          st_d = B_IDLE;
        end
      end
      B_IDLE: begin
        if (cmd_pop_o) begin
          st_d = B_CHK;
        end
      end
      B_CHK: begin
        if (finish) begin
          st_d = B_IDLE;
        end
      end
      default: st_d = B_IDLE;
    endcase
  end

  // Control state, count, limit, output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= B_CLEAR;
      clr_q       <= '0;
      count_q     <= '0;
      max_q       <= fhs_pkg::MAX_ENTRIES_RST;
      out_valid_q <= 1'b0;
      full_q      <= 1'b0;
    end else begin
      st_q    <= st_d;
      count_q <= count_nx;
      if (st_q == B_CLEAR) begin
        clr_q <= clr_q + SLOT_W'(1);
      end
      if (cfg_we_i) begin
        max_q <= cfg_wdata_i;
      end
      if (cmd_pop_o) begin
        full_q <= 1'b0;
      end else if (st_q == B_CHK && !finish && n_q == SLOT_W'(TABLE_SLOTS - 1)) begin
        full_q <= 1'b1;
      end
      if (finish) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Probe position and command payload
  always_ff @(posedge clk_i) begin
    if (cmd_pop_o) begin
      cmd_q  <= cmd_i;
      pos_q  <= cmd_slot_i;
      home_q <= cmd_slot_i;
      n_q    <= '0;
    end else if (st_q == B_CHK && !finish) begin
      pos_q <= pos_nx;
      n_q   <= n_q + SLOT_W'(1);
    end
  end

  // Result register
  always_ff @(posedge clk_i) begin
    if (finish) begin
      out_status_q <= res_status;
      out_pos_q    <= res_pos_ext[fhs_pkg::POS_W-1:0];
      out_count_q  <= count_nx;
      if (do_add) begin
        out_occ_q  <= 1'b1;
        out_text_q <= cmd_q.text;
        out_len_q  <= cmd_q.len;
      end else begin
        out_occ_q  <= ent_occ;
        out_text_q <= ent_text;
        out_len_q  <= ent_len;
      end
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_pos_o    = out_pos_q;
  assign out_occ_o    = out_occ_q;
  assign out_text_o   = out_text_q;
  assign out_len_o    = out_len_q;
  assign out_count_o  = out_count_q;

endmodule

// ----- rtl/fnv_hash_set_insert_top.sv -----
// Channel   | Dir | Beat contents
// s_axis    | in  | tuser: func; tdata: key_text, key_length, read_index
// m_axis    | out | tuser: status; tdata: slot_position .. stored_count
// cfg       | in  | max_entries, written when cfg_we_i is high
//
// In the front an insert runs one FNV round per key byte through one 32-bit
// multiplier; the back probes slots, one slot RAM read per cycle, until a free
// or matching slot is found or every slot is tried. A read skips the hash and
// reads one slot. Front and back overlap through a two-entry command queue,
// so the sustained rate is set by the slower of the two. After reset the
// store is cleared, one slot per cycle, with s_axis_tready low; configuration
// writes are taken throughout. A stalled m_axis beat holds the back end; the
// front keeps hashing until the command queue is full.
// Uses fhs_pkg, fhs_front, fhs_cmd_fifo, fhs_back.
module fnv_hash_set_insert_top #(
  parameter int TABLE_SLOTS = fhs_pkg::TABLE_SLOTS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [9:0]  cfg_wdata_i,    // max_entries
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [63:0] s_axis_tdata,   // key_text[47:0], key_length[50:48],
                                      // read_index[60:51], zero[63:61]
  input  logic [0:0]  s_axis_tuser,   // func[0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [71:0] m_axis_tdata,   // slot_position[9:0], slot_occupied[10],
                                      // slot_text[58:11], slot_length[61:59],
                                      // stored_count[71:62]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int SLOT_W = $clog2(TABLE_SLOTS);
  localparam int CMD_W  = $bits(fhs_pkg::key_cmd_t) + SLOT_W;

  logic                         clearing;
  logic                         push, fifo_full, pop, fifo_valid;
  fhs_pkg::key_cmd_t            push_cmd, pop_cmd;
  logic [SLOT_W-1:0]            push_slot, pop_slot;
  logic [fhs_pkg::STS_W-1:0]    out_status;
  logic [fhs_pkg::POS_W-1:0]    out_pos;
  logic                         out_occ;
  logic [fhs_pkg::TEXT_W-1:0]   out_text;
  logic [fhs_pkg::LEN_W-1:0]    out_len;
  logic [fhs_pkg::CNT_W-1:0]    out_count;

  fhs_front #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .clearing_i   (clearing),
    .in_valid_i   (s_axis_tvalid),
    .in_ready_o   (s_axis_tready),
    .func_i       (s_axis_tuser[0]),
    .key_text_i   (s_axis_tdata[47:0]),
    .key_length_i (s_axis_tdata[50:48]),
    .read_index_i (s_axis_tdata[60:51]),
    .push_o       (push),
    .push_cmd_o   (push_cmd),
    .push_slot_o  (push_slot),
    .fifo_full_i  (fifo_full)
  );

  fhs_cmd_fifo #(
    .DATA_W (CMD_W),
    .DEPTH  (fhs_pkg::CMD_FIFO_DEPTH)
  ) u_cmd_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i ({push_slot, push_cmd}),
    .full_o      (fifo_full),
    .pop_i       (pop),
    .valid_o     (fifo_valid),
    .pop_data_o  ({pop_slot, pop_cmd})
  );

  fhs_back #(
    .TABLE_SLOTS (TABLE_SLOTS)
  ) u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .clearing_o   (clearing),
    .cmd_valid_i  (fifo_valid),
    .cmd_i        (pop_cmd),
    .cmd_slot_i   (pop_slot),
    .cmd_pop_o    (pop),
    .out_valid_o  (m_axis_tvalid),
    .out_ready_i  (m_axis_tready),
    .out_status_o (out_status),
    .out_pos_o    (out_pos),
    .out_occ_o    (out_occ),
    .out_text_o   (out_text),
    .out_len_o    (out_len),
    .out_count_o  (out_count)
  );

  // Pack the result beat
  assign m_axis_tdata = {out_count, out_len, out_text, out_occ, out_pos};
  assign m_axis_tuser = out_status;

endmodule
